/* sv/bss_pkg.sv */
// Shared types, register codes and byte helpers for the byte substring search block.
`timescale 1ns / 1ps
`default_nettype none
package bss_pkg;

    // Default depth of the compare window, in bytes.
    localparam int PATTERN_MAX_DEF = 16;

    // A match must end below this absolute text position.
    localparam logic [32:0] TEXT_MAX = 33'd65536;

    // The byte counter saturates at this value.
    localparam logic [16:0] SEEN_LIMIT = 17'h1FFFF;

    // Configuration register indexes.
    localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [2:0] REG_FOLD_CASE    = 3'd3;
    localparam logic [2:0] REG_MATCH_ONLY   = 3'd4;
    localparam logic [2:0] REG_START_INDEX  = 3'd5;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [4:0]  pattern_length;
        logic        fold_case;
        logic        match_only;
        logic [15:0] start_index;
    } t_cfg;

    // Lower case for ASCII A to Z and Latin-1 capitals, the multiplication sign excluded.
    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic up;
        up = ((b >= 8'h41) && (b <= 8'h5A)) ||
             ((b >= 8'hC0) && (b <= 8'hDE) && (b != 8'hD7));
        return up ? (b + 8'h20) : b;
    endfunction

    // Pattern byte at an index; bytes past the sixteenth read as zero.
    function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                                input logic [4:0] idx);
        logic [127:0] pat;
        pat = {hi, lo};
        if (idx[4]) begin
            return 8'h00;
        end
        return pat[{idx[3:0], 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

/* sv/bss_cfg.sv */
// Configuration register bank of the byte substring search block.
`timescale 1ns / 1ps
`default_nettype none
module bss_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data,
    output bss_pkg::t_cfg      o_cfg
);
    import bss_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:  r_cfg.pattern_low    <= i_cfg_data;
                REG_PATTERN_HIGH: r_cfg.pattern_high   <= i_cfg_data;
                REG_PATTERN_LEN:  r_cfg.pattern_length <= i_cfg_data[4:0];
                REG_FOLD_CASE:    r_cfg.fold_case      <= i_cfg_data[0];
                REG_MATCH_ONLY:   r_cfg.match_only     <= i_cfg_data[0];
                REG_START_INDEX:  r_cfg.start_index    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* sv/bss_cell.sv */
// One window cell: holds a text byte, passes it on and compares the incoming byte.
`timescale 1ns / 1ps
`default_nettype none
module bss_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire logic          i_clear,
    input  wire logic [7:0]    i_byte,
    input  wire bss_pkg::t_cfg i_cfg,
    output logic [7:0]         o_byte,
    output logic               o_eq
);
    import bss_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       w_active;
    logic [4:0] w_pidx;
    logic [7:0] w_pat;
    logic [7:0] w_txt;

    // The byte arriving now is what this cell holds once the window has shifted.
    always_comb begin
        w_active = int'(i_cfg.pattern_length) > CELL_IDX;
        w_pidx   = i_cfg.pattern_length - 5'(CELL_IDX) - 5'd1;
        w_pat    = pattern_byte(i_cfg.pattern_low, i_cfg.pattern_high, w_pidx);
        w_txt    = i_byte;
        if (i_cfg.fold_case) begin
            w_pat = fold_byte(w_pat);
            w_txt = fold_byte(w_txt);
        end
        o_eq = !w_active || (w_pat == w_txt);
    end

    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = 8'h00;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule
`default_nettype wire

/* sv/byte_substring_search.sv */
// Top level of the byte substring search block: cell chain, counters and result register.
// A final item's result is registered; it is on the output in the cycle after acceptance.
// Throughput: one text item per cycle unless the output stalls; the window compare is done
// in parallel over the cell chain in the accepting cycle, and one result per text goes out.
// Reset (synchronous, active low) clears all registers, the window and the output register.
// No clearing pass is needed; the block accepts items in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module byte_substring_search #(
    parameter int PATTERN_MAX = bss_pkg::PATTERN_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // Text input.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // final_byte
    // Result output.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] match_position
    output logic             m_axis_tuser    // [0] found
);
    import bss_pkg::*;

    t_cfg w_cfg;

    bss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // An item is taken whenever the output register is free or is being emptied.
    logic w_accept;
    logic w_final;
    logic r_ov;

    assign s_axis_tready = !r_ov || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_final       = w_accept && s_axis_tlast;

    // The window is a chain of cells. Cell 0 sees the incoming byte, and every other cell
    // sees the byte held by its left neighbor, so each compare covers the window as it
    // will stand after this item is shifted in.
    logic [7:0]             w_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_eq;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            logic [7:0] w_in;
            if (k == 0) begin : g_head
                assign w_in = s_axis_tdata;
            end else begin : g_link
                assign w_in = w_byte[k-1];
            end
            bss_cell #(
                .CELL_IDX (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_clear (w_final),
                .i_byte  (w_in),
                .i_cfg   (w_cfg),
                .o_byte  (w_byte[k]),
                .o_eq    (w_eq[k])
            );
        end
    endgenerate

    // Per-text state: bytes seen so far (saturating), and the earliest hit.
    logic [16:0] r_seen;
    logic [16:0] n_seen;
    logic        r_hit;
    logic        n_hit;
    logic [15:0] r_pos;
    logic [15:0] n_pos;

    logic [17:0] w_abs;
    logic [17:0] w_seen1;
    logic [17:0] w_len;
    logic        w_len_ok;
    logic        w_try;
    logic        w_first;
    logic        w_match;

    always_comb begin
        w_abs    = 18'(w_cfg.start_index) + 18'(r_seen);
        w_seen1  = 18'(r_seen) + 18'd1;
        w_len    = 18'(w_cfg.pattern_length);
        w_len_ok = (w_cfg.pattern_length != 5'd0) &&
                   (int'(w_cfg.pattern_length) <= PATTERN_MAX);
        // A match can only be taken once the window holds a full pattern's worth of text,
        // while the counter has not saturated and the match ends below the text limit.
        w_try    = !r_hit && w_len_ok && (r_seen < SEEN_LIMIT) && (w_seen1 >= w_len) &&
                   (33'(w_abs) < TEXT_MAX);
        w_first  = (w_seen1 == w_len);
        w_match  = w_try && (!w_cfg.match_only || w_first) && (&w_eq);
    end

    always_comb begin
        n_seen = r_seen;
        n_hit  = r_hit;
        n_pos  = r_pos;
        if (w_accept) begin
            if (w_match) begin
                n_hit = 1'b1;
                n_pos = 16'(w_abs + 18'd1 - w_len);
            end
            if (r_seen < SEEN_LIMIT) begin
                n_seen = r_seen + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_hit  <= 1'b0;
            r_pos  <= '0;
        end else if (w_final) begin
            // The final byte was searched above; the next text starts from a clean slate.
            r_seen <= '0;
            r_hit  <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_seen <= n_seen;
            r_hit  <= n_hit;
            r_pos  <= n_pos;
        end
    end

    // Output register: loaded by a final item, held until the downstream side takes it.
    logic        r_found;
    logic [15:0] r_mpos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_final) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_mpos  <= 16'h0000;
        end else if (w_final) begin
            r_found <= n_hit;
            r_mpos  <= n_hit ? n_pos : 16'h0000;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_mpos;
    assign m_axis_tuser  = r_found;

    // A not-found result always carries a zero position.
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'h0000))
        else $error("not-found result carries a nonzero position");

    // A final item always leaves a result in the output register.
    a_final_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_final |=> m_axis_tvalid)
        else $error("final item produced no result");

    // Per-text state is cleared after a final item.
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_final |=> ((r_seen == 17'd0) && !r_hit))
        else $error("per-text state not cleared after final item");

    // A hit can only exist once at least one byte has been counted.
    a_hit_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (r_seen != 17'd0))
        else $error("hit recorded with no bytes seen");

endmodule
`default_nettype wire

/* verif/byte_substring_search_checker.sv */
// Checker for the byte substring search: tracks the search per text and compares every result.
`timescale 1ns / 1ps
module byte_substring_search_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_txt_valid,
    input  logic        i_txt_ready,
    input  logic [7:0]  i_txt_byte,
    input  logic        i_txt_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_pos,
    input  logic        i_res_found,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import bss_pkg::*;

    typedef struct packed {
        logic        found;
        logic [15:0] pos;
    } t_search_result;

    // Results owed by the block, oldest first.
    t_search_result pending_results [$];

    // Mirror of the configuration registers.
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic        fold_on;
    logic        anchor_only;
    logic [15:0] base_pos;

    // Per-text search state.
    logic [7:0]  window [16];
    logic [16:0] seen;
    logic        hit;
    logic [15:0] hit_pos;

    int mismatches = 0;
    int checked = 0;

    // ASCII capitals and Latin-1 capitals (the multiplication sign aside) get bit 5 set.
    function automatic logic [7:0] lower_case(input logic [7:0] b);
        if (b[7:5] == 3'b010 && b[4:0] >= 5'd1 && b[4:0] <= 5'd26) begin
            return b | 8'h20;
        end
        if (b[7:5] == 3'b110 && b[4:0] != 5'h17 && b[4:0] != 5'h1F) begin
            return b | 8'h20;
        end
        return b;
    endfunction

    // The newest pat_len window bytes against the pattern, oldest byte against pattern byte 0.
    function automatic logic window_equal();
        logic [127:0] pat;
        logic [7:0]   t;
        logic [7:0]   p;
        int           i;
        pat = {pat_hi, pat_lo};
        for (i = 0; i < pat_len; i++) begin
            t = window[pat_len - 1 - i];
            p = pat[i*8 +: 8];
            if (fold_on) begin
                t = lower_case(t);
                p = lower_case(p);
            end
            if (t != p) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : track
        t_search_result want;
        int unsigned    offset;
        int unsigned    first_off;
        int unsigned    pos_sum;
        int             k;
        if (!i_rst_n) begin
            pat_lo      = '0;
            pat_hi      = '0;
            pat_len     = '0;
            fold_on     = 1'b0;
            anchor_only = 1'b0;
            base_pos    = '0;
            for (k = 0; k < 16; k++) begin
                window[k] = 8'h00;
            end
            seen    = '0;
            hit     = 1'b0;
            hit_pos = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_LOW:  pat_lo = i_cfg_data;
                    REG_PATTERN_HIGH: pat_hi = i_cfg_data;
                    REG_PATTERN_LEN:  pat_len = i_cfg_data[4:0];
                    REG_FOLD_CASE:    fold_on = i_cfg_data[0];
                    REG_MATCH_ONLY:   anchor_only = i_cfg_data[0];
                    REG_START_INDEX:  base_pos = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Outputs are checked before the new item is taken, so a result and a final
            // byte on the same edge never pair up with each other.
            if (i_res_valid && i_res_ready) begin
                checked++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] result with none owed: found=%0b pos=%0d",
                                 $realtime, i_res_found, i_res_pos);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (want.found !== i_res_found || want.pos !== i_res_pos) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result %0d: found exp %0b got %0b, pos exp %0d got %0d",
                                     $realtime, checked, want.found, i_res_found,
                                     want.pos, i_res_pos);
                        end
                    end
                end
            end

            if (i_txt_valid && i_txt_ready) begin
                for (k = 15; k > 0; k--) begin
                    window[k] = window[k-1];
                end
                window[0] = i_txt_byte;
                offset = seen;

                // Only the earliest match is kept; it must end below the text limit.
                if (!hit && pat_len != 0 && pat_len <= 16 && seen != SEEN_LIMIT
                        && offset + 1 >= pat_len && base_pos + offset < TEXT_MAX) begin
                    first_off = offset + 1 - pat_len;
                    if ((!anchor_only || first_off == 0) && window_equal()) begin
                        hit     = 1'b1;
                        pos_sum = base_pos + first_off;
                        hit_pos = pos_sum[15:0];
                    end
                end
                if (seen != SEEN_LIMIT) begin
                    seen = seen + 17'd1;
                end

                if (i_txt_last) begin
                    want.found = hit;
                    want.pos   = hit ? hit_pos : 16'h0000;
                    pending_results.push_back(want);
                    for (k = 0; k < 16; k++) begin
                        window[k] = 8'h00;
                    end
                    seen    = '0;
                    hit     = 1'b0;
                    hit_pos = '0;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
        o_checked    <= checked;
    end

endmodule

/* verif/byte_substring_search_tb.sv */
// Testbench top for the byte substring search: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps
module byte_substring_search_tb;
    import bss_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        txt_valid = 1'b0;
    logic        txt_ready;
    logic [7:0]  txt_data = '0;
    logic        txt_last = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [15:0] res_pos;
    logic        res_found;

    int fail_count;
    int pending;
    int checked;

    // Pattern currently loaded, kept to build texts that hit or nearly hit it.
    logic [7:0] cur_pat [16];
    int         cur_len = 0;
    bit         cur_anchor = 0;

    logic [7:0] text_bytes [$];
    int         item_count = 0;
    int         text_count = 0;
    int         config_count = 0;

    bit send_idle = 0;
    bit recv_idle = 0;
    int hold_req = 0;
    localparam int HOLD_CYCLES = 300;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    byte_substring_search u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (txt_valid),
        .s_axis_tready (txt_ready),
        .s_axis_tdata  (txt_data),
        .s_axis_tlast  (txt_last),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_pos),
        .m_axis_tuser  (res_found)
    );

    byte_substring_search_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_txt_valid  (txt_valid),
        .i_txt_ready  (txt_ready),
        .i_txt_byte   (txt_data),
        .i_txt_last   (txt_last),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_pos    (res_pos),
        .i_res_found  (res_found),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Swaps upper and lower case for ASCII and Latin-1 letters; other bytes stay.
    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDE && b != 8'hD7)) begin
            return b + 8'h20;
        end
        if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'hE0 && b <= 8'hFE && b != 8'hF7)) begin
            return b - 8'h20;
        end
        return b;
    endfunction

    // Letters of both alphabets, bytes right at the borders of the folded ranges, and any byte.
    function automatic logic [7:0] letter_byte();
        case ($urandom_range(0, 5))
            0: return 8'h41 + 8'($urandom_range(0, 25));
            1: return 8'h61 + 8'($urandom_range(0, 25));
            2: return 8'hC0 + 8'($urandom_range(0, 31));
            3: return 8'hE0 + 8'($urandom_range(0, 31));
            4: begin
                case ($urandom_range(0, 9))
                    0: return 8'h40;
                    1: return 8'h5B;
                    2: return 8'h60;
                    3: return 8'h7B;
                    4: return 8'hD7;
                    5: return 8'hF7;
                    6: return 8'hDF;
                    7: return 8'hDE;
                    8: return 8'hBF;
                    default: return 8'hFF;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Drops valid, then waits until every owed result has been taken.
    task automatic wait_drained();
        txt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Loads all six registers while the block is idle.
    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi, input int len,
                              input bit fold, input bit anchor, input int start);
        logic [63:0] val;
        int          k;
        wait_drained();
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        val = 64'(len);
        write_reg(REG_PATTERN_LEN, val);
        val = 64'(fold);
        write_reg(REG_FOLD_CASE, val);
        val = 64'(anchor);
        write_reg(REG_MATCH_ONLY, val);
        val = 64'(start);
        write_reg(REG_START_INDEX, val);
        cfg_we <= 1'b0;
        for (k = 0; k < 8; k++) begin
            cur_pat[k]     = lo[k*8 +: 8];
            cur_pat[k + 8] = hi[k*8 +: 8];
        end
        cur_len    = len;
        cur_anchor = anchor;
        config_count++;
    endtask

    // Streams text_bytes with the final flag on the last one. Valid stays high after
    // the last item so a following text can go on without a gap.
    task automatic send_text();
        int gap;
        int k;
        for (k = 0; k < text_bytes.size(); k++) begin
            gap = send_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                txt_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            txt_valid <= 1'b1;
            txt_data  <= text_bytes[k];
            txt_last  <= (k == text_bytes.size() - 1);
            @(posedge clk);
            while (!(txt_valid && txt_ready)) begin
                @(posedge clk);
            end
            @(negedge clk);
            item_count++;
        end
        text_count++;
    endtask

    task automatic random_config();
        logic [127:0] pat;
        logic [7:0]   fill;
        int           sel;
        int           k;
        int           len;
        int           start;
        sel  = $urandom_range(0, 9);
        fill = letter_byte();
        for (k = 0; k < 16; k++) begin
            case (sel)
                0: pat[k*8 +: 8] = 8'h00;
                1: pat[k*8 +: 8] = 8'hFF;
                // A repeated letter gives overlapping candidates.
                2: pat[k*8 +: 8] = ($urandom_range(0, 3) == 0) ? flip_case(fill) : fill;
                default: pat[k*8 +: 8] = letter_byte();
            endcase
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            len = 0;
        end else if (sel == 1) begin
            len = $urandom_range(17, 31);
        end else if (sel <= 4) begin
            len = 16;
        end else if (sel <= 12) begin
            len = $urandom_range(1, 4);
        end else begin
            len = $urandom_range(1, 16);
        end
        // Starts close to the top of the position range exercise the text limit.
        sel = $urandom_range(0, 9);
        if (sel <= 2) begin
            start = 0;
        end else if (sel == 3) begin
            start = 65535;
        end else if (sel <= 5) begin
            start = 65535 - $urandom_range(0, 60);
        end else begin
            start = $urandom_range(0, 65535);
        end
        set_config(pat[63:0], pat[127:64], len, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0, start);
    endtask

    // Fills text_bytes with pattern pieces, case-swapped pieces and noise, and often
    // plants a whole (possibly case-swapped) copy of the pattern.
    task automatic build_text(input bit short_text);
        int n;
        int sel;
        int k;
        int at;
        logic [7:0] b;
        sel = $urandom_range(0, 19);
        if (short_text) begin
            n = $urandom_range(1, 3);
        end else if (sel <= 13) begin
            n = $urandom_range(1, 24);
        end else if (sel <= 17) begin
            n = $urandom_range(25, 60);
        end else if (cur_len >= 1 && cur_len <= 16) begin
            n = cur_len - 1 + $urandom_range(0, 2);
            if (n < 1) begin
                n = 1;
            end
        end else begin
            n = $urandom_range(1, 5);
        end
        text_bytes.delete();
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                b = cur_pat[$urandom_range(0, 15)];
            end else if (sel == 4) begin
                b = flip_case(cur_pat[$urandom_range(0, 15)]);
            end else if (sel < 8) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = letter_byte();
            end
            text_bytes.push_back(b);
        end
        if (cur_len >= 1 && cur_len <= 16 && n >= cur_len && $urandom_range(0, 1) == 1) begin
            at = (cur_anchor || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, n - cur_len);
            for (k = 0; k < cur_len; k++) begin
                b = cur_pat[k];
                if ($urandom_range(0, 3) == 0) begin
                    b = flip_case(b);
                end
                text_bytes[at + k] = b;
            end
        end
    endtask

    // Result side: a random stall before each result, or a long hold when asked.
    initial begin : result_sink
        int stall;
        @(negedge clk);
        forever begin
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = recv_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!(res_valid && res_ready)) begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int phase;
        int texts;
        bit squeeze;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts. Reset values give an empty pattern, which never matches.
        set_config(64'h0, 64'h0, 0, 0, 0, 0);
        text_bytes = '{8'h00};
        send_text();

        // Extreme byte values, exact compare, match at the very first position.
        set_config(64'hFF00, 64'h0, 2, 0, 0, 0);
        text_bytes = '{8'h00, 8'hFF};
        send_text();

        // Case folding across ASCII and Latin-1, match one byte in.
        set_config(64'h00C07A41, 64'h0, 3, 1, 0, 100);
        text_bytes = '{8'h41, 8'h61, 8'h5A, 8'hE0};
        send_text();

        // The multiplication sign is not folded, so its lowercase look-alike differs.
        set_config(64'hD7, 64'h0, 1, 1, 0, 7);
        text_bytes = '{8'hF7, 8'hD7};
        send_text();

        // Match-only mode: a later match is ignored, one at the first byte counts.
        set_config(64'hD7, 64'h0, 1, 1, 1, 7);
        text_bytes = '{8'hF7, 8'hD7};
        send_text();
        text_bytes = '{8'hD7};
        send_text();

        // Exact mode keeps upper and lower case apart.
        set_config(64'h6261, 64'h0, 2, 0, 0, 0);
        text_bytes = '{8'h41, 8'h62};
        send_text();

        // Oversized pattern length never matches, even against zero bytes.
        set_config(64'h0, 64'h0, 31, 0, 0, 0);
        text_bytes = '{8'h00, 8'h00};
        send_text();

        // Pattern longer than the text.
        set_config({8{8'h61}}, {8{8'h61}}, 16, 0, 0, 0);
        text_bytes = '{8'h61, 8'h61, 8'h61};
        send_text();

        // Text limit: a match ending at the last position counts, one past it does not.
        set_config(64'h6261, 64'h0, 2, 0, 0, 65534);
        text_bytes = '{8'h61, 8'h62};
        send_text();
        set_config(64'h6261, 64'h0, 2, 0, 0, 65535);
        text_bytes = '{8'h61, 8'h62};
        send_text();
        set_config(64'h61, 64'h0, 1, 0, 0, 65535);
        text_bytes = '{8'h61};
        send_text();

        // Random phases: a fresh configuration, then a handful of texts.
        phase = 0;
        while (item_count < 2000) begin
            random_config();
            squeeze   = (phase == 2);
            send_idle = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
            recv_idle = $urandom_range(0, 3) != 0;
            texts     = squeeze ? 25 : $urandom_range(2, 10);
            // One phase holds the result side off while short texts keep coming, so
            // the output register fills and the input has to stall.
            if (squeeze) begin
                hold_req = HOLD_CYCLES;
            end
            repeat (texts) begin
                build_text(squeeze);
                send_text();
            end
            phase++;
        end

        wait_drained();
        repeat (8) @(negedge clk);
        $display("Searched %0d text bytes in %0d texts over %0d configurations.",
                 item_count, text_count, config_count);
        $display("Compared %0d results, with one %0d-cycle hold on the result side.",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
